// ===== src/ft12d_pkg.sv =====
// ----------------------------------------------------------------------------
// ft12d_pkg: shared types and constants for the FT1.2 variable frame deframer
// Holds the command word passed from the classifier to the release stage.
// ----------------------------------------------------------------------------
package ft12d_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned TRL_W  = 2;
	localparam int unsigned REM_W  = 9;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// register indexes
	localparam logic REG_START_CODE    = 1'b0;
	localparam logic REG_TRAILER_COUNT = 1'b1;

	localparam logic [BYTE_W-1:0] START_CODE_RST    = 8'd104;
	localparam logic [TRL_W-1:0]  TRAILER_COUNT_RST = 2'd2;

	// One command describes all results caused by one input byte.
	// Result k carries cur for k == last_idx, else held for k == 0, len otherwise.
	typedef struct packed {
		logic [1:0]        last_idx;
		logic              in_frame;
		logic              frame_end;
		logic [BYTE_W-1:0] held;
		logic [BYTE_W-1:0] len;
		logic [BYTE_W-1:0] cur;
	} ft12d_cmd_t;

endpackage

// ===== src/ft12d_front.sv =====
// ----------------------------------------------------------------------------
// ft12d_front: header tracker and byte classifier
// Walks the header phases per byte and emits one release command per byte
// that produces output.
// ----------------------------------------------------------------------------
module ft12d_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ft12d_pkg::BYTE_W-1:0]  rx_byte,
	input  logic [ft12d_pkg::BYTE_W-1:0]  start_code,
	input  logic [ft12d_pkg::TRL_W-1:0]   trailer_count,
	input  logic                          q_full,
	output logic                          push,
	output ft12d_pkg::ft12d_cmd_t         cmd
);
	import ft12d_pkg::*;

	localparam logic [2:0] PH_SEARCH = 3'd0;
	localparam logic [2:0] PH_LEN1   = 3'd1;
	localparam logic [2:0] PH_LEN2   = 3'd2;
	localparam logic [2:0] PH_START2 = 3'd3;
	localparam logic [2:0] PH_BODY   = 3'd4;

	logic [2:0]        phase_q, phase_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] held_q, held_d;
	logic [REM_W-1:0]  rem_q, rem_d;
	logic [REM_W-1:0]  rem_sum;
	logic [REM_W-1:0]  rem_dec;
	logic              accept;
	logic              emit;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && emit;
	assign rem_sum  = REM_W'(len_q) + REM_W'(trailer_count);
	assign rem_dec  = (rem_q != '0) ? rem_q - REM_W'(1) : rem_q;

	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		held_d  = held_q;
		rem_d   = rem_q;
		emit    = 1'b0;
		cmd.last_idx  = 2'd0;
		cmd.in_frame  = 1'b0;
		cmd.frame_end = 1'b0;
		cmd.held      = held_q;
		cmd.len       = len_q;
		cmd.cur       = rx_byte;
		case (phase_q)
			PH_LEN1: begin
				len_d   = rx_byte;
				phase_d = PH_LEN2;
			end
			PH_LEN2: begin
				if (rx_byte == len_q) begin
					phase_d = PH_START2;
				end else begin
					emit         = 1'b1;
					cmd.last_idx = 2'd2;
					phase_d      = PH_SEARCH;
				end
			end
			PH_START2: begin
				emit         = 1'b1;
				cmd.last_idx = 2'd3;
				phase_d      = PH_SEARCH;
				if (rx_byte == held_q) begin
					cmd.in_frame  = 1'b1;
					cmd.frame_end = (rem_sum == '0);
					rem_d         = rem_sum;
					if (rem_sum != '0) begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				emit          = 1'b1;
				rem_d         = rem_dec;
				cmd.in_frame  = 1'b1;
				cmd.frame_end = (rem_dec == '0);
				if (rem_dec == '0) begin
					phase_d = PH_SEARCH;
				end
			end
			default: begin
				phase_d = PH_SEARCH;
				if (rx_byte == start_code) begin
					held_d  = rx_byte;
					phase_d = PH_LEN1;
				end else begin
					emit = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			len_q   <= '0;
			rem_q   <= '0;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			held_q  <= held_d;
		end
	end

`ifndef SYNTH
	a_body_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> rem_q != '0)
		else $error("body phase with no bytes left");
`endif

endmodule

// ===== src/ft12d_cmdq.sv =====
// ----------------------------------------------------------------------------
// ft12d_cmdq: command queue
// Small circular buffer between classifier and release stage.
// ----------------------------------------------------------------------------
module ft12d_cmdq #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ft12d_pkg::ft12d_cmd_t wr_cmd,
	input  logic                  pop,
	output ft12d_pkg::ft12d_cmd_t rd_cmd,
	output logic                  full,
	output logic                  empty
);
	import ft12d_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	ft12d_cmd_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full   = (cnt_q == CNT_FULL);
	assign empty  = (cnt_q == '0);
	assign rd_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full command queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty command queue");
`endif

endmodule

// ===== src/ft12d_back.sv =====
// ----------------------------------------------------------------------------
// ft12d_back: release stage
// Expands each command into one to four result bytes behind an output register.
// ----------------------------------------------------------------------------
module ft12d_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ft12d_pkg::ft12d_cmd_t         q_cmd,
	input  logic                          q_empty,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ft12d_pkg::BYTE_W-1:0]  out_byte,
	output logic                          in_frame,
	output logic                          frame_end,
	output logic                          last
);
	import ft12d_pkg::*;

	ft12d_cmd_t        cur_q;
	logic              cur_valid_q;
	logic [1:0]        idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              frame_q;
	logic              end_q;
	logic              last_q;
	logic              adv;
	logic              final_res;
	logic [BYTE_W-1:0] sel_byte;

	assign adv       = cur_valid_q && (!out_valid_q || !out_stall);
	assign final_res = (idx_q == cur_q.last_idx);
	assign pop       = !q_empty && (!cur_valid_q || (adv && final_res));

	always_comb begin
		if (final_res) begin
			sel_byte = cur_q.cur;
		end else if (idx_q == 2'd0) begin
			sel_byte = cur_q.held;
		end else begin
			sel_byte = cur_q.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (adv) begin
				if (final_res) begin
					cur_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_cmd;
		end
		if (adv) begin
			byte_q  <= sel_byte;
			frame_q <= cur_q.in_frame;
			end_q   <= cur_q.frame_end && final_res;
			last_q  <= final_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign in_frame  = frame_q;
	assign frame_end = end_q;
	assign last      = last_q;

`ifndef SYNTH
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> idx_q <= cur_q.last_idx)
		else $error("result index past end of command");
`endif

endmodule

// ===== src/ft12_variable_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// ft12_variable_frame_deframer_top: FT1.2 variable frame deframer
// Finds variable frames in a received byte stream and tags every byte as
// frame or garbage, flagging the final byte of each frame.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   rx_byte
//  out      source     out_valid / out_stall out_byte, in_frame, frame_end, last
//  cfg      APB slave  psel/penable/pready   paddr, pwdata, prdata
//
// One input byte is taken per cycle while the command queue has room.
// Results leave at one per cycle from the output register while out_stall is
// low; a confirmed or refuted header releases three or four results for its last
// byte, so the release stage sets the sustained rate of one result per cycle.
// Each result passes through the command queue, command register and output register.
// Reset clears the header tracker, queue and output valid; registers return
// to start_code 104, trailer_count 2. out_stall backs up through the queue
// to in_stall only once QUEUE_DEPTH commands are waiting.
// ----------------------------------------------------------------------------
module ft12_variable_frame_deframer_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input byte stream
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ft12d_pkg::BYTE_W-1:0]   rx_byte,
	// result stream
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ft12d_pkg::BYTE_W-1:0]   out_byte,
	output logic                           in_frame,
	output logic                           frame_end,
	output logic                           last,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ft12d_pkg::PADDR_W-1:0]  paddr,
	input  logic [ft12d_pkg::PDATA_W-1:0]  pwdata,
	output logic [ft12d_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready
);
	import ft12d_pkg::*;

	logic [BYTE_W-1:0] start_code_q;
	logic [TRL_W-1:0]  trailer_count_q;
	logic              reg_idx;
	logic              wr_en;

	ft12d_cmd_t        push_cmd;
	ft12d_cmd_t        head_cmd;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;

	// registers sit at byte addresses 0 and 4
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q    <= START_CODE_RST;
			trailer_count_q <= TRAILER_COUNT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_CODE:    start_code_q    <= pwdata[BYTE_W-1:0];
				REG_TRAILER_COUNT: trailer_count_q <= pwdata[TRL_W-1:0];
				default:           start_code_q    <= start_code_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START_CODE:    prdata = PDATA_W'(start_code_q);
			REG_TRAILER_COUNT: prdata = PDATA_W'(trailer_count_q);
			default:           prdata = '0;
		endcase
	end

	// classifier: tracks the header and decides what each byte releases
	ft12d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.start_code    (start_code_q),
		.trailer_count (trailer_count_q),
		.q_full        (q_full),
		.push          (push),
		.cmd           (push_cmd)
	);

	// decouples classification from release
	ft12d_cmdq #(
		.DEPTH (QUEUE_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.pop    (pop),
		.rd_cmd (head_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	// release stage: one result transfer per cycle while out_stall is low
	ft12d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_cmd     (head_cmd),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.in_frame  (in_frame),
		.frame_end (frame_end),
		.last      (last)
	);

endmodule
